### hdl/tccb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tccb_pkg
// Types and fixed codes shared by the text console cell buffer.
// ----------------------------------------------------------------------------
package tccb_pkg;

  // Function codes carried in the input tuser field.
  localparam logic [1:0] FN_PRINT = 2'd0;
  localparam logic [1:0] FN_KEY   = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;
  localparam logic [1:0] FN_READ  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // Character codes.
  localparam logic [7:0] KEY_BS   = 8'd8;
  localparam logic [7:0] KEY_NL   = 8'd10;
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;
  localparam logic [7:0] BLANK    = 8'h20;

  // Columns taken by the prompt; backspace never moves left of it.
  localparam int PROMPT_COLS = 2;

  // Widths of the stream payloads.
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 40;

  // Sequencer states.
  typedef enum logic [9:0] {
    ST_CLEAR     = 10'b0000000001,
    ST_IDLE      = 10'b0000000010,
    ST_EXEC      = 10'b0000000100,
    ST_PUT       = 10'b0000001000,
    ST_CP_RD     = 10'b0000010000,
    ST_CP_WR     = 10'b0000100000,
    ST_FILL      = 10'b0001000000,
    ST_READ_WAIT = 10'b0010000000,
    ST_RESP      = 10'b0100000000,
    ST_SPARE     = 10'b1000000000
  } state_t;

  // Direction of a cell copy pass.
  typedef enum logic [1:0] {
    CP_SCROLL = 2'd0,
    CP_LEFT   = 2'd1,
    CP_RIGHT  = 2'd2
  } cp_mode_t;

endpackage
`default_nettype wire

### hdl/text_console_cell_buffer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cell_buffer_core
// Character-cell screen store with a cursor, print, key edit, clear and read.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the s_ stream (func in s_tuser, the rest in s_tdata) and
//   each one gives exactly one result on the m_ stream. Register writes use
//   the cfg_ channel, which is always ready.
//   The block works on one item at a time through a small sequencer around
//   a cell memory with one write port and one registered read port.
//   Work per item: a read, a newline without a scroll or an ignored key needs
//   no copy pass; a print writes its byte; a key insert first shifts the row
//   right from the last column down to the cursor; a backspace shifts the
//   rest of the row left and blanks its last column; a scroll copies each
//   row up and blanks the last row; a clear writes spaces to every cell.
//   The copy passes move one cell at a time, a read and then a write,
//   through the memory port.
//   After reset a clearing pass fills every cell of the store with spaces;
//   no item is taken then.
//   A result waits in the output register while the receiver stalls, and the
//   next item is already accepted; its result waits until that transfer.
// ----------------------------------------------------------------------------
module text_console_cell_buffer_core #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 128
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Input stream.
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // s_tdata, lowest bit up: char_code[7:0], read_row[12:8], read_col[19:13].
  input  wire logic [tccb_pkg::IN_DATA_W-1:0]   s_tdata,
  // s_tuser: func[1:0].
  input  wire logic [tccb_pkg::IN_USER_W-1:0]   s_tuser,
  // Result stream.
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // m_tdata, lowest bit up: cursor_col[6:0], cursor_row[11:7],
  // cell_char[19:12], scrolled[20], scroll_count[36:21].
  output logic [tccb_pkg::OUT_DATA_W-1:0]       m_tdata,
  // Configuration write channel.
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic                             cfg_index,
  input  wire logic [7:0]                       cfg_data
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RNW   = $clog2(MAX_ROWS + 1);
  localparam int CNW   = $clog2(MAX_COLS + 1);
  localparam int AW    = RW + CW;
  localparam int DEPTH = MAX_ROWS * (2 ** CW);

  // Effective row count from a register value.
  function automatic logic [RNW-1:0] eff_r(input logic [5:0] v);
    logic [RNW-1:0] r;
    if (v == 6'd0) begin
      r = RNW'(1);
    end else if (32'(v) > MAX_ROWS) begin
      r = RNW'(MAX_ROWS);
    end else begin
      r = RNW'(v);
    end
    return r;
  endfunction

  // Effective column count from a register value.
  function automatic logic [CNW-1:0] eff_c(input logic [7:0] v);
    logic [CNW-1:0] c;
    if (v < 8'd3) begin
      c = CNW'(3);
    end else if (32'(v) > MAX_COLS) begin
      c = CNW'(MAX_COLS);
    end else begin
      c = CNW'(v);
    end
    return c;
  endfunction

  tccb_pkg::state_t   state, state_next;
  tccb_pkg::cp_mode_t mode, mode_next;

  logic [5:0]    rows_reg;
  logic [7:0]    cols_reg;
  logic [CW-1:0] cur_col, cur_col_next;
  logic [RW-1:0] cur_row, cur_row_next;
  logic [15:0]   scroll_total, scroll_total_next;
  logic [CW-1:0] it_col, it_col_next;
  logic [RW-1:0] it_row, it_row_next;
  logic          clr_op, clr_op_next;
  logic          scrolled, scrolled_next;
  logic [7:0]    cell_val, cell_val_next;

  // Captured item.
  logic [1:0] req_func;
  logic [7:0] req_code;
  logic [4:0] req_row;
  logic [6:0] req_col;

  // Cell memory port.
  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          mem_we;

  logic [RNW-1:0] eff_rows, new_rows;
  logic [CNW-1:0] eff_cols, new_cols;
  logic [RW-1:0]  last_row;
  logic [CW-1:0]  last_col;
  logic [RW-1:0]  src_row;
  logic [CW-1:0]  src_col;
  logic           in_accept;
  logic           out_load;
  logic           read_in_range;
  logic           nr;

  assign eff_rows = eff_r(rows_reg);
  assign eff_cols = eff_c(cols_reg);
  assign last_row = RW'(eff_rows - RNW'(1));
  assign last_col = CW'(eff_cols - CNW'(1));
  assign new_rows = eff_r(cfg_data[5:0]);
  assign new_cols = eff_c(cfg_data);

  assign s_tready  = (state == tccb_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_accept = s_tvalid && s_tready;
  assign out_load  = (state == tccb_pkg::ST_RESP) && (!m_tvalid || m_tready);

  assign read_in_range = (32'(req_row) < MAX_ROWS) && (32'(req_col) < MAX_COLS);

  // Source cell of a copy step, one step away from the destination.
  always_comb begin
    src_row = it_row;
    src_col = it_col;
    case (mode)
      tccb_pkg::CP_SCROLL: src_row = it_row + RW'(1);
      tccb_pkg::CP_LEFT:   src_col = it_col + CW'(1);
      tccb_pkg::CP_RIGHT:  src_col = it_col - CW'(1);
      default:             src_col = it_col;
    endcase
  end

  // The copy pass reads its source; otherwise the port serves the read item.
  assign raddr = (state == tccb_pkg::ST_CP_RD) ? {src_row, src_col}
                                               : {RW'(req_row), CW'(req_col)};

  // Sequencer.
  always_comb begin
    state_next        = state;
    mode_next         = mode;
    cur_col_next      = cur_col;
    cur_row_next      = cur_row;
    scroll_total_next = scroll_total;
    it_col_next       = it_col;
    it_row_next       = it_row;
    clr_op_next       = clr_op;
    scrolled_next     = scrolled;
    cell_val_next     = cell_val;
    mem_we            = 1'b0;
    waddr             = {it_row, it_col};
    wdata             = tccb_pkg::BLANK;
    nr                = 1'b0;

    case (state)
      tccb_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (it_row == RW'(MAX_ROWS - 1) && (&it_col)) begin
          state_next  = clr_op ? tccb_pkg::ST_RESP : tccb_pkg::ST_IDLE;
          clr_op_next = 1'b0;
        end else begin
          {it_row_next, it_col_next} = {it_row, it_col} + AW'(1);
        end
      end

      tccb_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_next    = tccb_pkg::ST_EXEC;
          scrolled_next = 1'b0;
          cell_val_next = 8'd0;
        end
      end

      tccb_pkg::ST_EXEC: begin
        case (req_func)
          tccb_pkg::FN_PRINT: begin
            if (req_code == tccb_pkg::KEY_NL) begin
              nr = 1'b1;
            end else begin
              state_next = tccb_pkg::ST_PUT;
            end
          end
          tccb_pkg::FN_KEY: begin
            if (req_code == tccb_pkg::KEY_BS) begin
              // Delete left of the cursor and pull the rest of the row in.
              if (32'(cur_col) > tccb_pkg::PROMPT_COLS) begin
                cur_col_next = cur_col - CW'(1);
                it_row_next  = cur_row;
                it_col_next  = cur_col - CW'(1);
                mode_next    = tccb_pkg::CP_LEFT;
                state_next   = tccb_pkg::ST_CP_RD;
              end else begin
                state_next = tccb_pkg::ST_RESP;
              end
            end else if (req_code inside {[tccb_pkg::PRINT_LO:tccb_pkg::PRINT_HI]}) begin
              // Push the row right from the last column down to the cursor.
              if (cur_col == last_col) begin
                state_next = tccb_pkg::ST_PUT;
              end else begin
                it_row_next = cur_row;
                it_col_next = last_col;
                mode_next   = tccb_pkg::CP_RIGHT;
                state_next  = tccb_pkg::ST_CP_RD;
              end
            end else begin
              state_next = tccb_pkg::ST_RESP;
            end
          end
          tccb_pkg::FN_CLEAR: begin
            cur_col_next = '0;
            cur_row_next = '0;
            it_col_next  = '0;
            it_row_next  = '0;
            clr_op_next  = 1'b1;
            state_next   = tccb_pkg::ST_CLEAR;
          end
          tccb_pkg::FN_READ: begin
            // The read address is on the port during this cycle.
            state_next = read_in_range ? tccb_pkg::ST_READ_WAIT : tccb_pkg::ST_RESP;
          end
          default: state_next = tccb_pkg::ST_RESP;
        endcase
      end

      tccb_pkg::ST_PUT: begin
        mem_we = 1'b1;
        waddr  = {cur_row, cur_col};
        wdata  = req_code;
        if (cur_col == last_col) begin
          nr = 1'b1;
        end else begin
          cur_col_next = cur_col + CW'(1);
          state_next   = tccb_pkg::ST_RESP;
        end
      end

      tccb_pkg::ST_CP_RD: begin
        state_next = tccb_pkg::ST_CP_WR;
      end

      tccb_pkg::ST_CP_WR: begin
        mem_we     = 1'b1;
        wdata      = rdata;
        state_next = tccb_pkg::ST_CP_RD;
        case (mode)
          tccb_pkg::CP_SCROLL: begin
            if (it_col == last_col) begin
              it_col_next = '0;
              if (src_row == last_row) begin
                it_row_next = last_row;
                state_next  = tccb_pkg::ST_FILL;
              end else begin
                it_row_next = src_row;
              end
            end else begin
              it_col_next = it_col + CW'(1);
            end
          end
          tccb_pkg::CP_LEFT: begin
            it_col_next = src_col;
            if (src_col == last_col) begin
              state_next = tccb_pkg::ST_FILL;
            end
          end
          tccb_pkg::CP_RIGHT: begin
            it_col_next = src_col;
            if (src_col == cur_col) begin
              state_next = tccb_pkg::ST_PUT;
            end
          end
          default: state_next = tccb_pkg::ST_RESP;
        endcase
      end

      tccb_pkg::ST_FILL: begin
        // Blank up to the last column of the row in it_row.
        mem_we = 1'b1;
        if (it_col == last_col) begin
          state_next = tccb_pkg::ST_RESP;
        end else begin
          it_col_next = it_col + CW'(1);
        end
      end

      tccb_pkg::ST_READ_WAIT: begin
        cell_val_next = rdata;
        state_next    = tccb_pkg::ST_RESP;
      end

      tccb_pkg::ST_RESP: begin
        if (!m_tvalid || m_tready) begin
          state_next = tccb_pkg::ST_IDLE;
        end
      end

      default: state_next = tccb_pkg::ST_CLEAR;
    endcase

    // Move to the start of the next row, scrolling from the last row.
    if (nr) begin
      cur_col_next = '0;
      if (cur_row == last_row) begin
        scrolled_next     = 1'b1;
        scroll_total_next = scroll_total + 16'd1;
        it_col_next       = '0;
        it_row_next       = '0;
        mode_next         = tccb_pkg::CP_SCROLL;
        state_next        = (last_row == '0) ? tccb_pkg::ST_FILL : tccb_pkg::ST_CP_RD;
      end else begin
        cur_row_next = cur_row + RW'(1);
        state_next   = tccb_pkg::ST_RESP;
      end
    end

    // A register write pulls the cursor back into the area in use.
    if (cfg_valid && cfg_index == tccb_pkg::CFG_ROWS) begin
      if (RNW'(cur_row_next) >= new_rows) begin
        cur_row_next = RW'(new_rows - RNW'(1));
      end
    end else if (cfg_valid && cfg_index == tccb_pkg::CFG_COLS) begin
      if (CNW'(cur_col_next) >= new_cols) begin
        cur_col_next = CW'(new_cols - CNW'(1));
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tccb_pkg::ST_CLEAR;
      mode         <= tccb_pkg::CP_SCROLL;
      rows_reg     <= 6'd24;
      cols_reg     <= 8'd80;
      cur_col      <= '0;
      cur_row      <= '0;
      scroll_total <= 16'd0;
      it_col       <= '0;
      it_row       <= '0;
      clr_op       <= 1'b0;
      scrolled     <= 1'b0;
      cell_val     <= 8'd0;
    end else begin
      state        <= state_next;
      mode         <= mode_next;
      cur_col      <= cur_col_next;
      cur_row      <= cur_row_next;
      scroll_total <= scroll_total_next;
      it_col       <= it_col_next;
      it_row       <= it_row_next;
      clr_op       <= clr_op_next;
      scrolled     <= scrolled_next;
      cell_val     <= cell_val_next;
      if (cfg_valid && cfg_index == tccb_pkg::CFG_ROWS) begin
        rows_reg <= cfg_data[5:0];
      end else if (cfg_valid && cfg_index == tccb_pkg::CFG_COLS) begin
        cols_reg <= cfg_data;
      end
    end
  end

  // Item capture on an input transfer.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_func <= s_tuser[1:0];
      req_code <= s_tdata[7:0];
      req_row  <= s_tdata[12:8];
      req_col  <= s_tdata[19:13];
    end
  end

  // Cell memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'b000, scroll_total, scrolled, cell_val, 5'(cur_row), 7'(cur_col)};
    end
  end

  // The cursor stays inside the area in use, also across register writes.
  assert property (@(posedge clk) disable iff (rst)
    (cur_col <= last_col) && (cur_row <= last_row))
    else $error("cursor outside the area in use");

  // A result that reports a scroll leaves the cursor on the last row.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[20]) |-> (m_tdata[11:7] == 5'(last_row)))
    else $error("scroll result with cursor off the last row");

  // A right shift never reaches past the cursor column.
  assert property (@(posedge clk) disable iff (rst)
    (state == tccb_pkg::ST_CP_WR && mode == tccb_pkg::CP_RIGHT) |-> (it_col > cur_col))
    else $error("insert shift passed the cursor");

  // An accepted item is decoded in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == tccb_pkg::ST_EXEC))
    else $error("accepted item not decoded");

endmodule
`default_nettype wire
